>>> rtl/tcw_pkg.sv
`default_nettype none

package tcw_pkg;

	// screen geometry
	localparam int WIDTH        = 80;
	localparam int HEIGHT       = 25;
	localparam int CELLS        = WIDTH * HEIGHT;
	localparam int SCROLL_CELLS = WIDTH * (HEIGHT - 1);
	localparam int ADDR_W       = $clog2(CELLS);
	localparam int ROW_W        = $clog2(HEIGHT + 1);

	// payload widths
	localparam int OP_W    = 2;
	localparam int CHAR_W  = 8;
	localparam int COLOR_W = 16;
	localparam int POS_W   = 11;

	// reciprocal for cursor / WIDTH, exact for any POS_W-bit cursor
	localparam int DIV_SHIFT = POS_W + $clog2(WIDTH);
	localparam int DIV_MUL   = ((2 ** DIV_SHIFT) + WIDTH - 1) / WIDTH;
	localparam int DIV_MUL_W = $clog2(DIV_MUL + 1);

	localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
	localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;

	typedef enum logic [OP_W-1:0] {
		OP_PUT    = 2'd0,
		OP_CLEAR  = 2'd1,
		OP_READ   = 2'd2,
		OP_SETCUR = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_COPY,
		ST_BLANK,
		ST_CLEAR,
		ST_ROW,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic load;
		logic zero;
		logic copy;
		logic row;
		logic end_scroll;
		logic exec;
	} cmd_t;

	typedef struct packed {
		logic cursor_full;
		logic newline;
		logic copy_last;
		logic zero_last;
		logic out_free;
	} status_t;

endpackage

`default_nettype wire

>>> rtl/text_console_writer.sv
// Text-mode console engine holding an 80 x 25 buffer of 16-bit character cells
// and a cursor. Each request (op: put char, clear, read cell, set cursor)
// returns one response with the resulting cursor, the read cell word and a
// scroll flag. A newline also finds the row of the cursor with a registered
// reciprocal multiply. Clear blanks every cell, and a put char at the end of
// the screen first scrolls: the cell memory, with one read and one write port,
// moves or blanks one cell per cycle. After reset the block clears the memory
// before in_ready first rises. A finished response waits in an output
// register, so the next request is taken while it is still pending.
`default_nettype none

module text_console_writer (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// request channel
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tcw_pkg::OP_W-1:0]    op,
	input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [tcw_pkg::COLOR_W-1:0] color,
	input  wire logic [tcw_pkg::POS_W-1:0]   position,
	// response channel
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic [tcw_pkg::POS_W-1:0]        cursor_pos,
	output logic [tcw_pkg::COLOR_W-1:0]      read_data,
	output logic                             scrolled
);
	import tcw_pkg::*;

	// command and status between sequencer and datapath
	cmd_t    cmd;
	status_t status;

	// sequencer: init clear, scroll copy and blank, clear sweep, row lookup
	tcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.char_code (char_code),
		.status    (status),
		.in_ready  (in_ready),
		.cmd       (cmd)
	);

	// cell memory, cursor, sweep counter and response register
	tcw_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.op         (op),
		.char_code  (char_code),
		.color      (color),
		.position   (position),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.cursor_pos (cursor_pos),
		.read_data  (read_data),
		.scrolled   (scrolled)
	);

endmodule

`default_nettype wire

>>> rtl/tcw_ctrl.sv
`default_nettype none

module tcw_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	input  wire logic [tcw_pkg::OP_W-1:0]   op,
	input  wire logic [tcw_pkg::CHAR_W-1:0] char_code,
	input  wire tcw_pkg::status_t           status,
	output logic                            in_ready,
	output tcw_pkg::cmd_t                   cmd
);
	import tcw_pkg::*;

	state_t state_q;
	state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.zero = 1'b1;
				if (status.zero_last) begin
					state_nxt = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					priority if (op == OP_CLEAR) begin
						state_nxt = ST_CLEAR;
					end else if (op == OP_PUT && status.cursor_full) begin
						state_nxt = ST_COPY;
					end else if (op == OP_PUT && char_code == CH_NEWLINE) begin
						state_nxt = ST_ROW;
					end else begin
						state_nxt = ST_EXEC;
					end
				end
			end
			ST_COPY: begin
				cmd.copy = 1'b1;
				if (status.copy_last) begin
					state_nxt = ST_BLANK;
				end
			end
			ST_BLANK: begin
				cmd.zero = 1'b1;
				if (status.zero_last) begin
					cmd.end_scroll = 1'b1;
					state_nxt      = status.newline ? ST_ROW : ST_EXEC;
				end
			end
			ST_CLEAR: begin
				cmd.zero = 1'b1;
				if (status.zero_last) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_ROW: begin
				cmd.row   = 1'b1;
				state_nxt = ST_EXEC;
			end
			ST_EXEC: begin
				if (status.out_free) begin
					cmd.exec  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/tcw_datapath.sv
`default_nettype none

module tcw_datapath (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire tcw_pkg::cmd_t               cmd,
	output tcw_pkg::status_t                 status,
	input  wire logic [tcw_pkg::OP_W-1:0]    op,
	input  wire logic [tcw_pkg::CHAR_W-1:0]  char_code,
	input  wire logic [tcw_pkg::COLOR_W-1:0] color,
	input  wire logic [tcw_pkg::POS_W-1:0]   position,
	input  wire logic                        out_ready,
	output logic                             out_valid,
	output logic [tcw_pkg::POS_W-1:0]        cursor_pos,
	output logic [tcw_pkg::COLOR_W-1:0]      read_data,
	output logic                             scrolled
);
	import tcw_pkg::*;

	// latched request
	op_t                op_q;
	logic [CHAR_W-1:0]  char_q;
	logic [COLOR_W-1:0] color_q;
	logic [POS_W-1:0]   pos_q;
	logic               rd_ok_q;

	// console state
	logic [POS_W-1:0]  cursor_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [ROW_W-1:0]  row_q;
	logic              scr_q;

	// cell memory
	logic [COLOR_W-1:0] mem [CELLS];
	logic [COLOR_W-1:0] mem_rdata_q;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [COLOR_W-1:0] mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;

	// result register
	logic               out_valid_q;
	logic [POS_W-1:0]   cursor_out_q;
	logic [COLOR_W-1:0] rdata_out_q;
	logic               scr_out_q;

	logic                       is_bs;
	logic [POS_W-1:0]           bs_cursor;
	logic [POS_W-1:0]           nl_cursor;
	logic [POS_W-1:0]           set_cursor;
	logic [POS_W-1:0]           exec_cursor;
	logic [POS_W+DIV_MUL_W-1:0] row_prod;

	assign status.cursor_full = (cursor_q == POS_W'(CELLS));
	assign status.newline     = (op_q == OP_PUT) && (char_q == CH_NEWLINE);
	assign status.copy_last   = (cnt_q == ADDR_W'(SCROLL_CELLS));
	assign status.zero_last   = (cnt_q == ADDR_W'(CELLS - 1));
	assign status.out_free    = !out_valid_q || out_ready;

	assign is_bs      = (char_q == CH_BACKSPACE);
	assign bs_cursor  = (cursor_q == '0) ? '0 : cursor_q - 1'b1;
	assign nl_cursor  = POS_W'(({1'b0, row_q} + 1'b1) * WIDTH);
	assign set_cursor = (pos_q > POS_W'(CELLS)) ? POS_W'(CELLS) : pos_q;
	assign row_prod   = cursor_q * DIV_MUL_W'(DIV_MUL);

	always_comb begin
		unique case (op_q)
			OP_PUT: begin
				if (status.newline) begin
					exec_cursor = nl_cursor;
				end else if (is_bs) begin
					exec_cursor = bs_cursor;
				end else begin
					exec_cursor = cursor_q + 1'b1;
				end
			end
			OP_CLEAR:  exec_cursor = '0;
			OP_READ:   exec_cursor = cursor_q;
			OP_SETCUR: exec_cursor = set_cursor;
			default:   exec_cursor = cursor_q;
		endcase
	end

	// memory port selection
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_re    = 1'b0;
		mem_raddr = '0;
		priority if (cmd.load) begin
			mem_re    = (op == OP_READ) && (position < POS_W'(CELLS));
			mem_raddr = ADDR_W'(position);
		end else if (cmd.copy) begin
			mem_re    = !status.copy_last;
			mem_raddr = cnt_q + ADDR_W'(WIDTH);
			mem_we    = (cnt_q != '0);
			mem_waddr = cnt_q - 1'b1;
			mem_wdata = mem_rdata_q;
		end else if (cmd.zero) begin
			mem_we    = 1'b1;
			mem_waddr = cnt_q;
		end else if (cmd.exec && op_q == OP_PUT && !status.newline) begin
			mem_we    = 1'b1;
			mem_waddr = is_bs ? ADDR_W'(bs_cursor) : ADDR_W'(cursor_q);
			mem_wdata = is_bs ? '0 : (color_q | COLOR_W'(char_q));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q    <= op_t'(op);
			char_q  <= char_code;
			color_q <= color;
			pos_q   <= position;
			rd_ok_q <= (position < POS_W'(CELLS));
		end
		if (cmd.row) begin
			row_q <= ROW_W'(row_prod >> DIV_SHIFT);
		end
		if (cmd.exec) begin
			cursor_out_q <= exec_cursor;
			rdata_out_q  <= (op_q == OP_READ && rd_ok_q) ? mem_rdata_q : '0;
			scr_out_q    <= scr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q    <= '0;
			cnt_q       <= '0;
			scr_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				cnt_q <= '0;
				scr_q <= 1'b0;
			end else if (cmd.copy) begin
				cnt_q <= status.copy_last ? cnt_q : cnt_q + 1'b1;
			end else if (cmd.zero) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.end_scroll) begin
				cursor_q <= POS_W'(SCROLL_CELLS);
				scr_q    <= 1'b1;
			end else if (cmd.exec) begin
				cursor_q <= exec_cursor;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign cursor_pos = cursor_out_q;
	assign read_data  = rdata_out_q;
	assign scrolled   = scr_out_q;

endmodule

`default_nettype wire
